@@ sv/rational_number_alu_defines.svh @@
// assertion macros for the rational number alu
`ifndef RATIONAL_NUMBER_ALU_DEFINES_SVH
`define RATIONAL_NUMBER_ALU_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define RNA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define RNA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RNA_ASSERT_NOW(label, ante, cons, msg)
`define RNA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ sv/rna_pkg.sv @@
package rna_pkg;

	localparam int FIELD_W         = 16;
	localparam int FUNC_W          = 3;
	localparam int NUM_W           = 34;
	localparam int DEN_W           = 33;
	localparam int OPERAND_W_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_NEG,
		OP_CMP,
		OP_NONE,   // unused function code, plain 0/1
		OP_ZDEN    // zero denominator, 0/1 with flag
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sa;  // sign of a after normalizing
		logic sb;  // sign of b after normalizing
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

@@ sv/rna_in_if.sv @@
interface rna_in_if import rna_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic signed [FIELD_W-1:0] a_num;
	logic signed [FIELD_W-1:0] a_den;
	logic signed [FIELD_W-1:0] b_num;
	logic signed [FIELD_W-1:0] b_den;

	modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ sv/rna_out_if.sv @@
interface rna_out_if import rna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0]        res_den;
	logic                    less;
	logic                    equal;
	logic                    zero_den;

	modport source (output valid, res_num, res_den, less, equal, zero_den, input ready);
	modport sink (input valid, res_num, res_den, less, equal, zero_den, output ready);
endinterface

@@ sv/rna_front.sv @@
module rna_front import rna_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rna_in_if.sink                   operands,
	output logic                     valid_s1,
	input  logic                     ready,
	output cls_t                     cls_s1,
	output logic [OPERAND_WIDTH-1:0] ma_s1,
	output logic [OPERAND_WIDTH-1:0] da_s1,
	output logic [OPERAND_WIDTH-1:0] mb_s1,
	output logic [OPERAND_WIDTH-1:0] db_s1
);

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD,
		FN_SUB,
		FN_MUL,
		FN_DIV,
		FN_NEG,
		FN_CMP
	} func_t;

	// sign and magnitude of a field read at OPERAND_WIDTH bits
	function automatic logic [OPERAND_WIDTH:0] split(input logic [FIELD_W-1:0] raw);
		logic [OPERAND_WIDTH+FIELD_W-1:0] ext;
		logic [OPERAND_WIDTH-1:0]         x;
		logic [OPERAND_WIDTH-1:0]         m;
		ext = (OPERAND_WIDTH+FIELD_W)'(raw);
		x   = ext[OPERAND_WIDTH-1:0];
		m   = x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
		return {x[OPERAND_WIDTH-1], m};
	endfunction

	logic                     an_neg, ad_neg, bn_neg, bd_neg;
	logic [OPERAND_WIDTH-1:0] ma, da, mb, db;
	logic                     sa, sb, zd, take;
	op_t                      op_d;

	assign {an_neg, ma} = split($unsigned(operands.a_num));
	assign {ad_neg, da} = split($unsigned(operands.a_den));
	assign {bn_neg, mb} = split($unsigned(operands.b_num));
	assign {bd_neg, db} = split($unsigned(operands.b_den));

	assign sa = (an_neg != ad_neg) && (ma != '0);
	assign sb = (bn_neg != bd_neg) && (mb != '0);

	always_comb begin
		zd = (da == '0) || ((operands.func != FN_NEG) && (db == '0)) ||
		     ((operands.func == FN_DIV) && (mb == '0));
		unique case (operands.func)
			FN_ADD:  op_d = OP_ADD;
			FN_SUB:  op_d = OP_SUB;
			FN_MUL:  op_d = OP_MUL;
			FN_DIV:  op_d = OP_DIV;
			FN_NEG:  op_d = OP_NEG;
			FN_CMP:  op_d = OP_CMP;
			default: op_d = OP_NONE;
		endcase
		if ((op_d != OP_NONE) && zd) begin
			op_d = OP_ZDEN;
		end
	end

	assign operands.ready = !valid_s1 || ready;
	assign take           = operands.valid && operands.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (operands.ready) begin
			valid_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= '{op: op_d, sa: sa, sb: sb};
			ma_s1  <= ma;
			da_s1  <= da;
			mb_s1  <= mb;
			db_s1  <= db;
		end
	end

endmodule

@@ sv/rna_queue.sv @@
module rna_queue import rna_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/rna_back.sv @@
module rna_back import rna_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     ready,
	input  cls_t                     cls,
	input  logic [OPERAND_WIDTH-1:0] ma,
	input  logic [OPERAND_WIDTH-1:0] da,
	input  logic [OPERAND_WIDTH-1:0] mb,
	input  logic [OPERAND_WIDTH-1:0] db,
	rna_out_if.source                result
);

	localparam int W   = OPERAND_WIDTH;
	localparam int PW  = 2 * W;
	localparam int N   = 2 * W + 1;
	localparam int KW  = $clog2(N);
	localparam int DCW = $clog2(N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMB,
		ST_GCD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic             sa_q, sb_q;
	logic [W-1:0]     ma_q, da_q, mb_q, db_q;
	logic [1:0]       step_q;
	logic [PW-1:0]    p0_q, p1_q, p2_q;
	logic             neg_q, lt_q, eq_q, zd_q;
	logic [N-1:0]     nm_q, dn_q, gx_q, gy_q, g_q;
	logic [KW-1:0]    k_q;
	logic [N-1:0]     qn_q, qd_q, rn_q, rd_q;
	logic [DCW-1:0]   cnt_q;
	logic             out_valid_q;
	logic [NUM_W-1:0] res_num_q;
	logic [DEN_W-1:0] res_den_q;
	logic             less_q, equal_q, zden_q;

	// shared multiplier
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] prod;
	logic [1:0]    last_step;

	always_comb begin
		case (step_q)
			2'd0: begin
				mul_a = ma_q;
				mul_b = (op_q == OP_MUL) ? mb_q : db_q;
			end
			2'd1: begin
				mul_a = (op_q == OP_MUL) ? da_q : mb_q;
				mul_b = (op_q == OP_MUL) ? db_q : da_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = db_q;
			end
		endcase
	end

	assign prod      = PW'(mul_a) * PW'(mul_b);
	assign last_step = ((op_q == OP_ADD) || (op_q == OP_SUB)) ? 2'd2 : 2'd1;

	// combine products into signed numerator, denominator and flags
	logic [N-1:0] p_ext, q_ext, s_mag, c_mag, c_den;
	logic         q_neg, s_neg, c_neg, c_lt, c_eq, c_zd;

	always_comb begin
		p_ext = N'(p0_q);
		q_ext = N'(p1_q);
		q_neg = (op_q == OP_SUB) ? !sb_q : sb_q;
		if (p1_q == '0) begin
			q_neg = 1'b0;
		end
		if (sa_q == q_neg) begin
			s_neg = sa_q;
			s_mag = p_ext + q_ext;
		end else if (p_ext >= q_ext) begin
			s_neg = sa_q;
			s_mag = p_ext - q_ext;
		end else begin
			s_neg = q_neg;
			s_mag = q_ext - p_ext;
		end
		if (s_mag == '0) begin
			s_neg = 1'b0;
		end
		c_neg = 1'b0;
		c_mag = '0;
		c_den = N'(1);
		c_lt  = 1'b0;
		c_eq  = 1'b0;
		c_zd  = 1'b0;
		unique case (op_q) inside
			OP_ADD, OP_SUB: begin
				c_neg = s_neg;
				c_mag = s_mag;
				c_den = N'(p2_q);
			end
			OP_MUL, OP_DIV: begin
				c_neg = sa_q ^ sb_q;
				c_mag = p_ext;
				c_den = q_ext;
			end
			OP_NEG: begin
				c_neg = !sa_q;
				c_mag = N'(ma_q);
				c_den = N'(da_q);
			end
			OP_CMP: begin
				c_eq = (sa_q == sb_q) && (p0_q == p1_q);
				if (sa_q != sb_q) begin
					c_lt = sa_q;
				end else if (sa_q) begin
					c_lt = p0_q > p1_q;
				end else begin
					c_lt = p0_q < p1_q;
				end
			end
			OP_ZDEN: begin
				c_zd = 1'b1;
			end
			default: begin
				c_zd = 1'b0;
			end
		endcase
	end

	// one binary gcd iteration
	logic [N-1:0]  gx_d, gy_d, g_d;
	logic [KW-1:0] k_d;
	logic          gcd_done;

	always_comb begin
		gx_d = gx_q;
		gy_d = gy_q;
		k_d  = k_q;
		if (!gx_q[0] && !gy_q[0]) begin
			gx_d = gx_q >> 1;
			gy_d = gy_q >> 1;
			k_d  = k_q + 1'b1;
		end else if (!gx_q[0]) begin
			gx_d = gx_q >> 1;
		end else if (!gy_q[0]) begin
			gy_d = gy_q >> 1;
		end else if (gx_q >= gy_q) begin
			gx_d = (gx_q - gy_q) >> 1;
		end else begin
			gy_d = (gy_q - gx_q) >> 1;
		end
	end

	assign gcd_done = (gx_q == '0) || (gy_q == '0);
	assign g_d      = (gx_q | gy_q) << k_q;

	// two restoring dividers sharing the divisor, one bit a cycle
	logic [N:0]   tn, td;
	logic [N-1:0] rn_d, rd_d;
	logic         bn, bd;

	always_comb begin
		tn = {rn_q, qn_q[N-1]};
		td = {rd_q, qd_q[N-1]};
		bn = (tn >= {1'b0, g_q});
		bd = (td >= {1'b0, g_q});
		rn_d = bn ? N'(tn - {1'b0, g_q}) : tn[N-1:0];
		rd_d = bd ? N'(td - {1'b0, g_q}) : td[N-1:0];
	end

	// signed output forms, truncated to the port widths
	logic [N+NUM_W-1:0] num_x, num_s;
	logic [N+DEN_W-1:0] den_x;
	logic               out_free, out_load;

	assign num_x    = (N+NUM_W)'(qn_q);
	assign num_s    = neg_q ? (~num_x + 1'b1) : num_x;
	assign den_x    = (N+DEN_W)'(qd_q);
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_FIN) && out_free;
	assign ready    = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NONE;
			sa_q        <= 1'b0;
			sb_q        <= 1'b0;
			ma_q        <= '0;
			da_q        <= '0;
			mb_q        <= '0;
			db_q        <= '0;
			step_q      <= '0;
			p0_q        <= '0;
			p1_q        <= '0;
			p2_q        <= '0;
			neg_q       <= 1'b0;
			lt_q        <= 1'b0;
			eq_q        <= 1'b0;
			zd_q        <= 1'b0;
			nm_q        <= '0;
			dn_q        <= '0;
			gx_q        <= '0;
			gy_q        <= '0;
			g_q         <= '0;
			k_q         <= '0;
			qn_q        <= '0;
			qd_q        <= '0;
			rn_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			less_q      <= 1'b0;
			equal_q     <= 1'b0;
			zden_q      <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						op_q   <= cls.op;
						sa_q   <= cls.sa;
						sb_q   <= cls.sb;
						ma_q   <= ma;
						da_q   <= da;
						mb_q   <= mb;
						db_q   <= db;
						step_q <= '0;
						if ((cls.op == OP_NEG) || (cls.op == OP_NONE) ||
						    (cls.op == OP_ZDEN)) begin
							state_q <= ST_COMB;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					case (step_q)
						2'd0:    p0_q <= prod;
						2'd1:    p1_q <= prod;
						default: p2_q <= prod;
					endcase
					step_q <= step_q + 1'b1;
					if (step_q == last_step) begin
						state_q <= ST_COMB;
					end
				end
				ST_COMB: begin
					lt_q <= c_lt;
					eq_q <= c_eq;
					zd_q <= c_zd;
					if ((c_mag == '0) || (c_den == '0)) begin
						neg_q   <= 1'b0;
						qn_q    <= '0;
						qd_q    <= N'(1);
						state_q <= ST_FIN;
					end else begin
						neg_q   <= c_neg;
						nm_q    <= c_mag;
						dn_q    <= c_den;
						gx_q    <= c_mag;
						gy_q    <= c_den;
						k_q     <= '0;
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_done) begin
						g_q     <= g_d;
						qn_q    <= nm_q;
						qd_q    <= dn_q;
						rn_q    <= '0;
						rd_q    <= '0;
						cnt_q   <= DCW'(N - 1);
						state_q <= ST_DIV;
					end else begin
						gx_q <= gx_d;
						gy_q <= gy_d;
						k_q  <= k_d;
					end
				end
				ST_DIV: begin
					rn_q  <= rn_d;
					rd_q  <= rd_d;
					qn_q  <= {qn_q[N-2:0], bn};
					qd_q  <= {qd_q[N-2:0], bd};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_num_q   <= num_s[NUM_W-1:0];
						res_den_q   <= den_x[DEN_W-1:0];
						less_q      <= lt_q;
						equal_q     <= eq_q;
						zden_q      <= zd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid    = out_valid_q;
	assign result.res_num  = $signed(res_num_q);
	assign result.res_den  = res_den_q;
	assign result.less     = less_q;
	assign result.equal    = equal_q;
	assign result.zero_den = zden_q;

endmodule

@@ sv/rational_number_alu.sv @@
// rational number alu: add, subtract, multiply, divide, negate or compare two
// signed fractions a = a_num/a_den and b = b_num/b_den.
// operands channel: valid/ready transaction carrying func and the four fields,
// read as two's complement at OPERAND_WIDTH bits.
// result channel: valid/ready transaction carrying the reduced res_num/res_den
// (denominator positive, sign on the numerator), less, equal and zero_den.
// the back end loads a transaction, runs two multiplies (three for add and
// subtract; none for negate, unused codes or zero denominators), combines, then
// runs binary gcd iterations (at most about 2*(2*OPERAND_WIDTH+1)) and
// 2*OPERAND_WIDTH+1 divide steps before the output register; compare, zero
// results and zero denominators skip the gcd and the divide.
// throughput is one transaction per back-end run, set by the one-iteration-
// a-cycle gcd loop followed by the bit-serial divider pair.
// the front stage and the queue keep taking operands while the back end works,
// so up to QUEUE_DEPTH + 1 transactions wait ahead of it.
// a finished result sits in the output register; the back end starts the next
// transaction as soon as that register is loaded, and waits only when a second
// result is ready while the receiver still stalls the first.
// reset empties the front stage, the queue and the output register.
`include "rational_number_alu_defines.svh"

module rational_number_alu import rna_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_W_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rna_in_if.sink    operands,
	rna_out_if.source result
);

	localparam int ENTRY_W = CLS_W + 4 * OPERAND_WIDTH;

	// front stage outputs
	logic                     front_valid, front_ready;
	cls_t                     front_cls;
	logic [OPERAND_WIDTH-1:0] front_ma, front_da, front_mb, front_db;

	// queue to back end
	logic                     back_valid, back_ready;
	logic [ENTRY_W-1:0]       push_data, pop_data;
	cls_t                     back_cls;
	logic [OPERAND_WIDTH-1:0] back_ma, back_da, back_mb, back_db;

	// classify and normalize signs
	rna_front #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.valid_s1 (front_valid),
		.ready    (front_ready),
		.cls_s1   (front_cls),
		.ma_s1    (front_ma),
		.da_s1    (front_da),
		.mb_s1    (front_mb),
		.db_s1    (front_db)
	);

	assign push_data = {front_cls, front_ma, front_da, front_mb, front_db};

	// decouples the front stage from the long back-end run
	rna_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (push_data),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (pop_data)
	);

	assign {back_cls, back_ma, back_da, back_mb, back_db} = pop_data;

	// products, gcd reduction and output register
	rna_back #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (back_valid),
		.ready  (back_ready),
		.cls    (back_cls),
		.ma     (back_ma),
		.da     (back_da),
		.mb     (back_mb),
		.db     (back_db),
		.result (result)
	);

	// an accepted transaction lands in the front stage
	`RNA_ASSERT_NEXT(a_front_load, operands.valid && operands.ready, front_valid, "front stage lost a transaction")
	// compare flags come only with a plain 0/1 result and no zero denominator
	`RNA_ASSERT_NOW(a_cmp_shape, result.valid && (result.less || result.equal), (result.res_num == '0) && (result.res_den == DEN_W'(1)) && !result.zero_den && !(result.less && result.equal), "bad compare result")
	// a zero denominator forces 0/1
	`RNA_ASSERT_NOW(a_zden_shape, result.valid && result.zero_den, (result.res_num == '0) && (result.res_den == DEN_W'(1)), "zero denominator result not 0/1")
	// reduced denominator stays positive while it fits the port
	`RNA_ASSERT_NOW(a_den_pos, result.valid && (OPERAND_WIDTH <= 16), result.res_den != '0, "zero result denominator")

endmodule
